// ----- rtl/core/rrss_pkg.sv -----
`timescale 1ns / 1ps

package rrss_pkg;

    // Corner radius width, and the width of the square-root argument r*r - dy*dy.
    localparam int R_W         = 14;
    localparam int SQ_ARG_W    = 2 * R_W;
    localparam int SQ_ROOT_W   = R_W;
    localparam int SQ_REM_W    = SQ_ROOT_W + 2;
    localparam int SQ_STEPS    = 2;
    localparam int SQ_STAGES   = SQ_ROOT_W / SQ_STEPS;

    // Fixed field widths of the register file and the result.
    localparam int SIZE_W      = 15;
    localparam int START_W     = 15;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT,
        CFG_RECT_TOP,
        CFG_RECT_WIDTH,
        CFG_RECT_HEIGHT,
        CFG_CORNER_RADIUS,
        CFG_DISPLAY_WIDTH
    } t_cfg_idx;

    // Per-item control that rides along the square-root pipeline.
    typedef struct packed {
        logic keep;   // row is inside the box and the box is not right of the display
        logic band;   // row lies in a rounded corner band
    } t_side;

endpackage

// ----- rtl/core/rrss_front.sv -----
`timescale 1ns / 1ps

module rrss_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic signed [COORD_BITS-1:0]      i_rect_left,
    input  logic signed [COORD_BITS-1:0]      i_rect_top,
    input  logic [rrss_pkg::SIZE_W-1:0]       i_rect_height,
    input  logic [rrss_pkg::R_W-1:0]          i_radius,
    input  logic [rrss_pkg::SIZE_W-1:0]       i_display_width,
    input  logic                              i_vld,
    input  logic signed [COORD_BITS-1:0]      i_scanline,
    output logic                              o_vld,
    output rrss_pkg::t_side                   o_side,
    output logic [rrss_pkg::SQ_ARG_W-1:0]     o_arg
);
    import rrss_pkg::*;

    localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

    logic signed [CW-1:0] y_x, top_x, left_x, h_x, r_x, dw_x;
    logic signed [CW-1:0] bottom_x, dyb_x, dyt_x;
    logic                 keep_c, band_b, band_t;

    logic [3:0]           r_vld;
    t_side                r_side [4];
    logic signed [R_W:0]  r1_dy;
    logic [R_W-1:0]       r2_dya;
    logic [SQ_ARG_W-1:0]  r3_dd, r3_rr, r4_arg;

    assign y_x    = {{(CW-COORD_BITS){i_scanline[COORD_BITS-1]}}, i_scanline};
    assign top_x  = {{(CW-COORD_BITS){i_rect_top[COORD_BITS-1]}}, i_rect_top};
    assign left_x = {{(CW-COORD_BITS){i_rect_left[COORD_BITS-1]}}, i_rect_left};
    assign h_x    = {{(CW-SIZE_W){1'b0}}, i_rect_height};
    assign r_x    = {{(CW-R_W){1'b0}}, i_radius};
    assign dw_x   = {{(CW-SIZE_W){1'b0}}, i_display_width};

    // Bottom band is checked first; its dy runs from 0 up, the top band's is negative.
    assign bottom_x = top_x + h_x;
    assign dyb_x    = y_x - bottom_x + r_x;
    assign dyt_x    = y_x - top_x - r_x;
    assign keep_c   = (y_x >= top_x) && (y_x < bottom_x) && !(left_x > dw_x);
    assign band_b   = !dyb_x[CW-1];
    assign band_t   = dyt_x[CW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0].keep <= keep_c;
            r_side[0].band <= keep_c && (band_b || band_t);
            r1_dy          <= band_b ? dyb_x[R_W:0] : dyt_x[R_W:0];
            r_side[1]      <= r_side[0];
            r2_dya         <= r1_dy[R_W] ? R_W'(-r1_dy) : r1_dy[R_W-1:0];
            r_side[2]      <= r_side[1];
            r3_dd          <= SQ_ARG_W'(r2_dya) * SQ_ARG_W'(r2_dya);
            r3_rr          <= SQ_ARG_W'(i_radius) * SQ_ARG_W'(i_radius);
            r_side[3]      <= r_side[2];
            r4_arg         <= r3_rr - r3_dd;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_side = r_side[3];
    assign o_arg  = r4_arg;

endmodule

// ----- rtl/core/rrss_isqrt.sv -----
`timescale 1ns / 1ps

module rrss_isqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_vld,
    input  rrss_pkg::t_side                   i_side,
    input  logic [rrss_pkg::SQ_ARG_W-1:0]     i_arg,
    output logic                              o_vld,
    output rrss_pkg::t_side                   o_side,
    output logic [rrss_pkg::SQ_ROOT_W-1:0]    o_root
);
    import rrss_pkg::*;

    logic [SQ_STAGES-1:0]  r_vld;
    t_side                 r_side [SQ_STAGES];
    logic [SQ_REM_W-1:0]   r_rem  [SQ_STAGES];
    logic [SQ_ROOT_W-1:0]  r_root [SQ_STAGES];
    logic [SQ_ARG_W-1:0]   r_arg  [SQ_STAGES];
    logic [SQ_REM_W-1:0]   n_rem  [SQ_STAGES];
    logic [SQ_ROOT_W-1:0]  n_root [SQ_STAGES];
    logic [SQ_ARG_W-1:0]   n_arg  [SQ_STAGES];

    // Restoring digit-by-digit root: two result bits per stage.
    always_comb begin
        logic [SQ_REM_W-1:0]   rem;
        logic [SQ_ROOT_W-1:0]  root;
        logic [SQ_ARG_W-1:0]   arg;
        logic [SQ_REM_W+1:0]   t;
        logic [SQ_REM_W+1:0]   trial;
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                rem  = '0;
                root = '0;
                arg  = i_arg;
            end else begin
                rem  = r_rem[k-1];
                root = r_root[k-1];
                arg  = r_arg[k-1];
            end
            for (int j = 0; j < SQ_STEPS; j++) begin
                t     = {rem, arg[SQ_ARG_W-1 -: 2]};
                arg   = arg << 2;
                trial = {2'b00, root, 2'b01};
                if (t >= trial) begin
                    rem  = SQ_REM_W'(t - trial);
                    root = {root[SQ_ROOT_W-2:0], 1'b1};
                end else begin
                    rem  = SQ_REM_W'(t);
                    root = {root[SQ_ROOT_W-2:0], 1'b0};
                end
            end
            n_rem[k]  = rem;
            n_root[k] = root;
            n_arg[k]  = arg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[SQ_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_arg[k]  <= n_arg[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_side = r_side[SQ_STAGES-1];
    assign o_root = r_root[SQ_STAGES-1];

endmodule

// ----- rtl/core/rrss_back.sv -----
`timescale 1ns / 1ps

module rrss_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic signed [COORD_BITS-1:0]      i_rect_left,
    input  logic [rrss_pkg::SIZE_W-1:0]       i_rect_width,
    input  logic [rrss_pkg::R_W-1:0]          i_radius,
    input  logic [rrss_pkg::SIZE_W-1:0]       i_display_width,
    input  logic                              i_vld,
    input  rrss_pkg::t_side                   i_side,
    input  logic [rrss_pkg::SQ_ROOT_W-1:0]    i_root,
    output logic                              o_vld,
    output logic                              o_span_valid,
    output logic [rrss_pkg::START_W-1:0]      o_span_start,
    output logic signed [COORD_BITS-1:0]      o_span_end
);
    import rrss_pkg::*;

    localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

    logic signed [CW-1:0]  left_x, w_x, off_x, dw_x;
    logic signed [CW-1:0]  s_c, e_c;
    logic                  ok_c;
    logic [R_W-1:0]        off;

    logic                  r_vld_a, r_keep_a, r_vld_b;
    logic signed [CW-1:0]  r_s_a, r_e_a;
    logic                  r_ok;
    logic [START_W-1:0]    r_start;
    logic signed [COORD_BITS-1:0] r_end;

    // Inside a band the root never exceeds the radius, so the pull-in is non-negative.
    assign off    = i_side.band ? (i_radius - i_root) : '0;
    assign left_x = {{(CW-COORD_BITS){i_rect_left[COORD_BITS-1]}}, i_rect_left};
    assign w_x    = {{(CW-SIZE_W){1'b0}}, i_rect_width};
    assign off_x  = {{(CW-R_W){1'b0}}, off};
    assign dw_x   = {{(CW-SIZE_W){1'b0}}, i_display_width};

    assign s_c  = r_s_a[CW-1] ? '0 : r_s_a;
    assign e_c  = (r_e_a > dw_x) ? (dw_x - CW'(1)) : r_e_a;
    assign ok_c = r_keep_a && (e_c > 0) && !(e_c < s_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_adv) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_keep_a <= i_side.keep;
            r_s_a    <= left_x + off_x;
            r_e_a    <= left_x + w_x - off_x;
            r_ok     <= ok_c;
            r_start  <= ok_c ? s_c[START_W-1:0] : '0;
            r_end    <= ok_c ? e_c[COORD_BITS-1:0] : '0;
        end
    end

    assign o_vld        = r_vld_b;
    assign o_span_valid = r_ok;
    assign o_span_start = r_start;
    assign o_span_end   = r_end;

endmodule

// ----- rtl/core/rounded_rect_scanline_span_top.sv -----
`timescale 1ns / 1ps

// Channel      Direction  Handshake                      Payload
// s_axis       in         s_axis_tvalid / s_axis_tready  tdata: scanline
// m_axis       out        m_axis_tvalid / m_axis_tready  tdata: span_start, span_end;
//                                                        tuser: span_valid
// i_cfg        in         i_cfg_wr_en (no wait)          i_cfg_addr, i_cfg_wdata
//
// The block takes one scanline request per clock unless m_axis stalls, and returns
// one span per request. The pipe has four front stages (range and band test, |dy|,
// squares, difference), seven square-root stages at two root bits each, and two back
// stages (pull-in and clipping), the last of which is the output register.
// Reset is synchronous and active low; it clears every stage valid bit and sets the
// registers to their reset values (display width 320, the rest zero).
// The whole pipe advances when the output register is empty or being taken, so a
// stall on m_axis freezes every stage and back-pressures s_axis in the same cycle.
// Registers are meant to be written only while no request is in flight.

module rounded_rect_scanline_span_top #(
    parameter  int COORD_BITS  = 16,
    localparam int CFG_W       = (COORD_BITS > 15) ? COORD_BITS : 15,
    localparam int IN_TDATA_W  = ((COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((rrss_pkg::START_W + COORD_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_wr_en,
    input  logic [rrss_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [CFG_W-1:0]                  i_cfg_wdata,
    // Scanline requests.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,   // scanline
    // Span results.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_TDATA_W-1:0]            m_axis_tdata,   // span_start, span_end
    output logic                              m_axis_tuser    // span_valid
);
    import rrss_pkg::*;

    logic signed [COORD_BITS-1:0] r_rect_left, r_rect_top;
    logic [SIZE_W-1:0]            r_rect_width, r_rect_height, r_display_width;
    logic [R_W-1:0]               r_corner_radius;

    logic                         adv;
    logic                         f_vld, q_vld, b_vld;
    t_side                        f_side, q_side;
    logic [SQ_ARG_W-1:0]          f_arg;
    logic [SQ_ROOT_W-1:0]         q_root;
    logic                         span_valid;
    logic [START_W-1:0]           span_start;
    logic signed [COORD_BITS-1:0] span_end;

    // Register file. Writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left     <= '0;
            r_rect_top      <= '0;
            r_rect_width    <= '0;
            r_rect_height   <= '0;
            r_corner_radius <= '0;
            r_display_width <= SIZE_W'(320);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_RECT_LEFT:     r_rect_left     <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_RECT_TOP:      r_rect_top      <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_RECT_WIDTH:    r_rect_width    <= i_cfg_wdata[SIZE_W-1:0];
                CFG_RECT_HEIGHT:   r_rect_height   <= i_cfg_wdata[SIZE_W-1:0];
                CFG_CORNER_RADIUS: r_corner_radius <= i_cfg_wdata[R_W-1:0];
                CFG_DISPLAY_WIDTH: r_display_width <= i_cfg_wdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One enable for the whole pipe: it moves whenever the output slot is free or drains.
    assign adv           = !b_vld || m_axis_tready;
    assign s_axis_tready = adv;

    rrss_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_rect_left     (r_rect_left),
        .i_rect_top      (r_rect_top),
        .i_rect_height   (r_rect_height),
        .i_radius        (r_corner_radius),
        .i_display_width (r_display_width),
        .i_vld           (s_axis_tvalid),
        .i_scanline      (s_axis_tdata[COORD_BITS-1:0]),
        .o_vld           (f_vld),
        .o_side          (f_side),
        .o_arg           (f_arg)
    );

    rrss_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_arg   (f_arg),
        .o_vld   (q_vld),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    rrss_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_rect_left     (r_rect_left),
        .i_rect_width    (r_rect_width),
        .i_radius        (r_corner_radius),
        .i_display_width (r_display_width),
        .i_vld           (q_vld),
        .i_side          (q_side),
        .i_root          (q_root),
        .o_vld           (b_vld),
        .o_span_valid    (span_valid),
        .o_span_start    (span_start),
        .o_span_end      (span_end)
    );

    assign m_axis_tvalid = b_vld;
    assign m_axis_tuser  = span_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-START_W-COORD_BITS){1'b0}}, span_end, span_start};

    // A row without a span carries all-zero coordinates.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("empty span with nonzero coordinates");

    // Reset flushes the pipe: nothing is presented right after it.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result presented right after reset");

    // Input back-pressure only comes from a result held at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

endmodule
